// ===== sv/fgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fgrc_pkg
// shared types and codes for the functional graph reach counter
// ----------------------------------------------------------------------------
package fgrc_pkg;

    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    // visit marks
    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] node_value;
        logic              last_edge;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]  read_index;
        logic [COUNT_W-1:0] visited_count;
        logic [STAT_W-1:0]  status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_OUT,
        OP_SOLVE,
        OP_CLR,
        OP_SCAN_RD,
        OP_NEXT_I,
        OP_WALK_START,
        OP_WALK_RD,
        OP_PUSH,
        OP_CYC_START,
        OP_LEN_RD,
        OP_LEN_STEP,
        OP_ASG,
        OP_ASG_STEP,
        OP_ASG_END,
        OP_CNT_RD,
        OP_CNT_LATCH,
        OP_UNW_RD,
        OP_UNW_WR
    } dp_op_t;

    typedef struct packed {
        logic       bad_now;
        logic       clr_done;
        logic       i_at_n;
        logic [1:0] mark_rd;
        logic       w_eq_v;
        logic       succ_eq_v;
        logic       depth_zero;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/fgrc_datapath.sv =====
// ----------------------------------------------------------------------------
// fgrc_datapath
// node tables, walk registers and result register
// ----------------------------------------------------------------------------
module fgrc_datapath #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fgrc_pkg::dp_op_t            op,
    input  logic [fgrc_pkg::NODE_W-1:0] node_value,
    output fgrc_pkg::dp_stat_t          stat,
    input  logic                        m_ready,
    output logic                        m_valid,
    output fgrc_pkg::out_item_t         m_data
);
    import fgrc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int XW = (NW > NODE_W) ? NW : NODE_W;

    logic [NODE_W-1:0] succ_mem  [MAX_NODES];
    logic [NW-1:0]     count_mem [MAX_NODES];
    logic [1:0]        mark_mem  [MAX_NODES];
    logic [AW-1:0]     stack_mem [MAX_NODES];

    logic              succ_we;
    logic [AW-1:0]     succ_wa, succ_ra;
    logic [NODE_W-1:0] succ_wd, succ_rd;
    logic              count_we;
    logic [AW-1:0]     count_wa, count_ra;
    logic [NW-1:0]     count_wd, count_rd;
    logic              mark_we;
    logic [AW-1:0]     mark_wa, mark_ra;
    logic [1:0]        mark_wd, mark_rd;
    logic              stack_we;
    logic [AW-1:0]     stack_wa, stack_ra, stack_wd, stack_rd;

    logic [NW-1:0]     n_reg, n_next;
    logic [NODE_W-1:0] max_reg, max_next;
    logic              ready_reg, ready_next;
    logic              bad_reg, bad_next;
    logic [NW-1:0]     i_reg, i_next;
    logic [AW-1:0]     v_reg, v_next;
    logic [AW-1:0]     w_reg, w_next;
    logic [NW-1:0]     depth_reg, depth_next;
    logic [NW-1:0]     len_reg, len_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [NODE_W-1:0] rq_reg, rq_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [NW-1:0]     eff_n, i_inc, depth_dec, cnt_inc;
    logic [NODE_W-1:0] eff_max;
    logic              out_free;

    assign eff_n     = ready_reg ? '0 : n_reg;
    assign eff_max   = ready_reg ? '0 : max_reg;
    assign i_inc     = i_reg + NW'(1);
    assign depth_dec = depth_reg - NW'(1);
    assign cnt_inc   = cnt_reg + NW'(1);
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        stat.bad_now    = XW'(max_reg) >= XW'(n_reg);
        stat.clr_done   = i_inc == n_reg;
        stat.i_at_n     = i_reg == n_reg;
        stat.mark_rd    = mark_rd;
        stat.w_eq_v     = w_reg == v_reg;
        stat.succ_eq_v  = AW'(succ_rd) == v_reg;
        stat.depth_zero = depth_reg == '0;
        stat.out_free   = out_free;
    end

    always_comb begin
        n_next         = n_reg;
        max_next       = max_reg;
        ready_next     = ready_reg;
        bad_next       = bad_reg;
        i_next         = i_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        depth_next     = depth_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        rq_next        = rq_reg;
        out_next       = out_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;

        succ_we  = 1'b0;
        succ_wa  = eff_n[AW-1:0];
        succ_wd  = node_value;
        succ_ra  = v_reg;
        count_we = 1'b0;
        count_wa = w_reg;
        count_wd = len_reg;
        count_ra = AW'(rq_reg);
        mark_we  = 1'b0;
        mark_wa  = w_reg;
        mark_wd  = MARK_DONE;
        mark_ra  = v_reg;
        stack_we = 1'b0;
        stack_wa = depth_reg[AW-1:0];
        stack_wd = v_reg;
        stack_ra = depth_dec[AW-1:0];

        case (op)
            OP_LOAD: begin
                ready_next = 1'b0;
                bad_next   = ready_reg ? 1'b0 : bad_reg;
                n_next     = eff_n;
                max_next   = eff_max;
                if (eff_n != NW'(MAX_NODES)) begin
                    succ_we  = 1'b1;
                    n_next   = eff_n + NW'(1);
                    max_next = (node_value > eff_max) ? node_value : eff_max;
                end
            end
            OP_READ: begin
                rq_next  = node_value;
                count_ra = AW'(node_value);
            end
            OP_OUT: begin
                out_valid_next   = 1'b1;
                out_next.read_index = rq_reg;
                if (!ready_reg || XW'(rq_reg) >= XW'(n_reg)) begin
                    out_next.status        = ST_RANGE;
                    out_next.visited_count = '0;
                end else if (bad_reg) begin
                    out_next.status        = ST_BAD;
                    out_next.visited_count = '0;
                end else begin
                    out_next.status        = ST_OK;
                    out_next.visited_count = COUNT_W'(count_rd);
                end
            end
            OP_SOLVE: begin
                ready_next = 1'b1;
                bad_next   = XW'(max_reg) >= XW'(n_reg);
                i_next     = '0;
            end
            OP_CLR: begin
                mark_we = 1'b1;
                mark_wa = i_reg[AW-1:0];
                mark_wd = MARK_NEW;
                i_next  = (i_inc == n_reg) ? '0 : i_inc;
            end
            OP_SCAN_RD: begin
                mark_ra = i_reg[AW-1:0];
            end
            OP_NEXT_I: begin
                i_next = i_inc;
            end
            OP_WALK_START: begin
                v_next     = i_reg[AW-1:0];
                depth_next = '0;
            end
            OP_WALK_RD: begin
                succ_ra = v_reg;
                mark_ra = v_reg;
            end
            OP_PUSH: begin
                mark_we    = 1'b1;
                mark_wa    = v_reg;
                mark_wd    = MARK_PATH;
                stack_we   = 1'b1;
                depth_next = depth_reg + NW'(1);
                v_next     = AW'(succ_rd);
            end
            OP_CYC_START: begin
                len_next = NW'(1);
                w_next   = AW'(succ_rd);
            end
            OP_LEN_RD: begin
                len_next = len_reg + NW'(1);
                succ_ra  = w_reg;
            end
            OP_LEN_STEP: begin
                w_next = AW'(succ_rd);
            end
            OP_ASG: begin
                count_we = 1'b1;
                mark_we  = 1'b1;
                succ_ra  = w_reg;
            end
            OP_ASG_STEP: begin
                w_next = AW'(succ_rd);
            end
            OP_ASG_END: begin
                depth_next = depth_reg - len_reg;
                cnt_next   = len_reg;
            end
            OP_CNT_RD: begin
                count_ra = v_reg;
            end
            OP_CNT_LATCH: begin
                cnt_next = count_rd;
            end
            OP_UNW_RD: begin
                depth_next = depth_dec;
            end
            OP_UNW_WR: begin
                count_we = 1'b1;
                count_wa = stack_rd;
                count_wd = cnt_inc;
                mark_we  = 1'b1;
                mark_wa  = stack_rd;
                cnt_next = cnt_inc;
            end
            default: begin
            end
        endcase
    end

    // node tables, registered read data
    always_ff @(posedge aclk) begin
        if (succ_we) begin
            succ_mem[succ_wa] <= succ_wd;
        end
        succ_rd <= succ_mem[succ_ra];
    end

    always_ff @(posedge aclk) begin
        if (count_we) begin
            count_mem[count_wa] <= count_wd;
        end
        count_rd <= count_mem[count_ra];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd <= mark_mem[mark_ra];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_rd <= stack_mem[stack_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            max_reg       <= '0;
            ready_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            n_reg         <= n_next;
            max_reg       <= max_next;
            ready_reg     <= ready_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
        i_reg     <= i_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        depth_reg <= depth_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        rq_reg    <= rq_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/fgrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgrc_ctrl
// sequencer for loads, reads and the graph walk
// ----------------------------------------------------------------------------
module fgrc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               command,
    input  logic               last_edge,
    input  fgrc_pkg::dp_stat_t stat,
    output fgrc_pkg::dp_op_t   op
);
    import fgrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SOLVE,
        S_CLR,
        S_SCAN,
        S_SCAN_T,
        S_WALK_RD,
        S_WALK_T,
        S_LEN_CHK,
        S_LEN_W,
        S_ASG,
        S_ASG_W,
        S_CNT_W,
        S_UNW,
        S_UNW_W
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (command == CMD_READ) begin
                        op         = OP_READ;
                        state_next = S_RD_WAIT;
                    end else begin
                        op = OP_LOAD;
                        if (last_edge) begin
                            state_next = S_SOLVE;
                        end
                    end
                end
            end
            S_RD_WAIT: begin
                if (stat.out_free) begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            S_SOLVE: begin
                op         = OP_SOLVE;
                state_next = stat.bad_now ? S_IDLE : S_CLR;
            end
            S_CLR: begin
                op = OP_CLR;
                if (stat.clr_done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.i_at_n) begin
                    state_next = S_IDLE;
                end else begin
                    op         = OP_SCAN_RD;
                    state_next = S_SCAN_T;
                end
            end
            S_SCAN_T: begin
                if (stat.mark_rd != MARK_NEW) begin
                    op         = OP_NEXT_I;
                    state_next = S_SCAN;
                end else begin
                    op         = OP_WALK_START;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                op         = OP_WALK_RD;
                state_next = S_WALK_T;
            end
            S_WALK_T: begin
                if (stat.mark_rd == MARK_NEW) begin
                    op         = OP_PUSH;
                    state_next = S_WALK_RD;
                end else if (stat.mark_rd == MARK_PATH) begin
                    op         = OP_CYC_START;
                    state_next = S_LEN_CHK;
                end else begin
                    op         = OP_CNT_RD;
                    state_next = S_CNT_W;
                end
            end
            S_LEN_CHK: begin
                if (stat.w_eq_v) begin
                    state_next = S_ASG;
                end else begin
                    op         = OP_LEN_RD;
                    state_next = S_LEN_W;
                end
            end
            S_LEN_W: begin
                op         = OP_LEN_STEP;
                state_next = S_LEN_CHK;
            end
            S_ASG: begin
                op         = OP_ASG;
                state_next = S_ASG_W;
            end
            S_ASG_W: begin
                if (stat.succ_eq_v) begin
                    op         = OP_ASG_END;
                    state_next = S_UNW;
                end else begin
                    op         = OP_ASG_STEP;
                    state_next = S_ASG;
                end
            end
            S_CNT_W: begin
                op         = OP_CNT_LATCH;
                state_next = S_UNW;
            end
            S_UNW: begin
                if (stat.depth_zero) begin
                    op         = OP_NEXT_I;
                    state_next = S_SCAN;
                end else begin
                    op         = OP_UNW_RD;
                    state_next = S_UNW_W;
                end
            end
            S_UNW_W: begin
                op         = OP_UNW_WR;
                state_next = S_UNW;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/functional_graph_reach_count.sv =====
// ----------------------------------------------------------------------------
// functional_graph_reach_count
// per-node count of reachable nodes in a graph with one out-edge per node
// ----------------------------------------------------------------------------
// Loads (command 0) store one successor per node in node order, one per
// cycle; a load with last_edge set starts the computation, during which
// s_ready is low. The computation first clears the visit marks, one node a
// cycle, then scans the nodes and walks the graph from each unvisited one
// with registered table reads: the walk pushes each new node on a stack,
// steps once around the graph cycle it closes to measure its length, writes
// that length to each cycle node, and on the way back gives each tail node
// its successor's count plus one. A graph with an edge target at or beyond
// the node count is flagged at once and skips the walk. A read (command 1)
// latches its index and table entry, then loads its result into the output
// register once that register is free, so s_ready is low in between and
// stays low while the output register is still held; reads and loads are
// taken only while no computation runs. A load after a computed graph
// starts a new graph; loads beyond MAX_NODES nodes are dropped.
// ----------------------------------------------------------------------------
module functional_graph_reach_count #(
    parameter int MAX_NODES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fgrc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fgrc_pkg::out_item_t m_data
);
    import fgrc_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    // sequencer: accepts transfers and steps the walk
    fgrc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .command   (s_data.command),
        .last_edge (s_data.last_edge),
        .stat      (stat),
        .op        (op)
    );

    // tables, walk registers and result register
    fgrc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .node_value (s_data.node_value),
        .stat       (stat),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule
